/* rtl/imu_sample_timestamp_scaler_macros.svh */
// Assertion macros for the IMU sample timestamp scaler
`ifndef IMU_SAMPLE_TIMESTAMP_SCALER_MACROS_SVH
`define IMU_SAMPLE_TIMESTAMP_SCALER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define IMU_STS_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IMU_STS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

/* rtl/imu_sts_pkg.sv */
// Shared types, constants and gain tables for the IMU sample timestamp scaler
`timescale 1ns / 1ps

package imu_sts_pkg;

    localparam int RAW_W      = 16;
    localparam int MAG_W      = RAW_W + 1;
    localparam int GAIN_W     = 23;
    localparam int FRAC_BITS  = 22;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int Q_W        = PROD_W - FRAC_BITS;
    localparam int CNT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int DT_W       = 20;
    localparam int RANGE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_RANGE  = 2'd0,
        CFG_ACCEL_RANGE = 2'd1,
        CFG_INTV_LIMIT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              new_sample;
        logic [DT_W-1:0]   interval_us;
        logic [TIME_W-1:0] sample_time_us;
    } time_res_t;

    function automatic logic [GAIN_W-1:0] gyro_gain(input logic [RANGE_W-1:0] sel);
        logic [GAIN_W-1:0] g;
        case (sel)
            3'd0:    g = 23'd4463684;
            3'd1:    g = 23'd2231842;
            3'd2:    g = 23'd1117625;
            3'd3:    g = 23'd558812;
            3'd4:    g = 23'd279406;
            3'd5:    g = 23'd139623;
            3'd6:    g = 23'd69812;
            3'd7:    g = 23'd34906;
            default: g = 23'd34906;
        endcase
        return g;
    endfunction

    function automatic logic [GAIN_W-1:0] accel_gain(input logic [RANGE_W-1:0] sel);
        logic [GAIN_W-1:0] g;
        case (sel)
            3'd1:    g = 23'd1024000;
            3'd2:    g = 23'd512000;
            3'd3:    g = 23'd256000;
            default: g = 23'd2048000;
        endcase
        return g;
    endfunction

endpackage

/* rtl/imu_sts_lane.sv */
// One scaling lane: magnitude multiply by the gain, then round and saturate
`timescale 1ns / 1ps

module imu_sts_lane (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic                                 ready,
    input  logic signed [imu_sts_pkg::RAW_W-1:0] raw,
    input  logic [imu_sts_pkg::GAIN_W-1:0]       gain,
    output logic signed [imu_sts_pkg::RAW_W-1:0] result
);
    import imu_sts_pkg::*;

    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              neg_reg;
    logic [PROD_W-1:0] rounded;
    logic [Q_W-1:0]    q;

    always_comb
    begin
        if (!ready)
        begin
            mag = '0;
        end
        else if (raw[RAW_W-1])
        begin
            mag = MAG_W'(-$signed({raw[RAW_W-1], raw}));
        end
        else
        begin
            mag = {1'b0, raw};
        end
        prod_next = PROD_W'(mag) * PROD_W'(gain);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            neg_reg  <= ready & raw[RAW_W-1];
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_comb
    begin
        rounded = prod_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        q       = rounded[PROD_W-1:FRAC_BITS];
        if (neg_reg)
        begin
            if (q > Q_W'(32768))
            begin
                result = 16'sh8000;
            end
            else
            begin
                result = RAW_W'(-q);
            end
        end
        else
        begin
            if (q > Q_W'(32767))
            begin
                result = 16'sh7FFF;
            end
            else
            begin
                result = q[RAW_W-1:0];
            end
        end
    end

endmodule

/* rtl/imu_sts_time.sv */
// Timer widening and sample interval check
`timescale 1ns / 1ps

module imu_sts_time (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic                               take,
    input  logic                               ready,
    input  logic [imu_sts_pkg::CNT_W-1:0]      timer_count,
    input  logic [imu_sts_pkg::DT_W-1:0]       limit,
    output imu_sts_pkg::time_res_t             res
);
    import imu_sts_pkg::*;

    logic [CNT_W-1:0]  last_cnt_reg;
    logic [TIME_W-1:0] wrap_reg;
    logic [TIME_W-1:0] wrap_next;
    logic [TIME_W-1:0] last_time_reg;
    logic              prev_valid_reg;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] diff;
    logic              ok;
    time_res_t         res_reg;
    time_res_t         res_next;

    always_comb
    begin
        wrap_next = (timer_count < last_cnt_reg) ? wrap_reg + (TIME_W'(1) << CNT_W)
                                                 : wrap_reg;
        now  = wrap_next + TIME_W'(timer_count);
        diff = now - last_time_reg;
        ok   = prev_valid_reg && (now >= last_time_reg) && (diff != '0)
               && (diff <= TIME_W'(limit));
        res_next = '0;
        if (ready)
        begin
            res_next.new_sample     = ok;
            res_next.interval_us    = ok ? diff[DT_W-1:0] : '0;
            res_next.sample_time_us = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg   <= '0;
            wrap_reg       <= '0;
            last_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (take && ready)
        begin
            last_cnt_reg   <= timer_count;
            wrap_reg       <= wrap_next;
            last_time_reg  <= now;
            prev_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/imu_sample_timestamp_scaler.sv */
// Top level of the IMU sample timestamp scaler: lanes, timer unit, output stage
// Usage:
//   s_* carries one sensor poll per word; s_tuser is the data-ready flag and
//   s_tdata the timer count and six raw axis counts. m_* carries one result
//   word per poll; m_tuser is the new-sample flag and m_tdata the interval,
//   widened timestamp and six scaled axes. cfg_we/cfg_index/cfg_data write
//   the gyro range, accel range and interval limit; write only while idle.
// Timing:
//   Two register stages: an accepted word passes the first stage and then
//   the output register before it shows on m_*. The first stage holds the
//   six lane products and the timer unit, the second the rounding,
//   saturation and the output register. One word per cycle is accepted
//   while the output register drains.
// Reset:
//   Clears the pipeline valids, the timer history and loads the default
//   range selections and interval limit.
// Stall:
//   While m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; the held result stays unchanged until taken.
`timescale 1ns / 1ps

module imu_sample_timestamp_scaler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // timer_count, accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [111:0]                          s_tdata,
    // sample_ready
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // interval_us, sample_time_us, accel_x_mg, accel_y_mg, accel_z_mg,
    // gyro_x_mrad, gyro_y_mrad, gyro_z_mrad, 4 zero bits
    output logic [151:0]                          m_tdata,
    // new_sample
    output logic                                  m_tuser,
    input  logic                                  cfg_we,
    input  logic [imu_sts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imu_sts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import imu_sts_pkg::*;

    localparam int LANES = 6;

    logic [RANGE_W-1:0] gyro_range_reg;
    logic [RANGE_W-1:0] accel_range_reg;
    logic [DT_W-1:0]    limit_reg;
    logic               adv;
    logic               take;
    logic               s1_valid_reg;
    logic               out_valid_reg;
    time_res_t          time_res;
    time_res_t          time_out_reg;
    logic [GAIN_W-1:0]  gyro_g;
    logic [GAIN_W-1:0]  accel_g;
    logic signed [RAW_W-1:0] lane_raw [LANES];
    logic signed [RAW_W-1:0] lane_res [LANES];
    logic [RAW_W-1:0]        axis_out_reg [LANES];

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign take     = s_tvalid && adv;
    assign gyro_g   = gyro_gain(gyro_range_reg);
    assign accel_g  = accel_gain(accel_range_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_range_reg  <= RANGE_W'(1);
            accel_range_reg <= RANGE_W'(2);
            limit_reg       <= DT_W'(100000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GYRO_RANGE:  gyro_range_reg  <= cfg_data[RANGE_W-1:0];
                CFG_ACCEL_RANGE: accel_range_reg <= cfg_data[RANGE_W-1:0];
                CFG_INTV_LIMIT:  limit_reg       <= cfg_data[DT_W-1:0];
                default:         ;
            endcase
        end
    end

    imu_sts_time u_time (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv),
        .take        (take),
        .ready       (s_tuser),
        .timer_count (s_tdata[15:0]),
        .limit       (limit_reg),
        .res         (time_res)
    );

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_lane
            assign lane_raw[gi] = s_tdata[(gi+1)*RAW_W +: RAW_W];
            imu_sts_lane u_lane (
                .clk    (clk),
                .load   (adv),
                .ready  (s_tuser),
                .raw    (lane_raw[gi]),
                .gain   ((gi < 3) ? accel_g : gyro_g),
                .result (lane_res[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s_tvalid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // merge lane results and timer result into the output word
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            time_out_reg <= time_res;
            for (int i = 0; i < LANES; i++)
            begin
                axis_out_reg[i] <= lane_res[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = time_out_reg.new_sample;
    assign m_tdata  = {4'd0,
                       axis_out_reg[5], axis_out_reg[4], axis_out_reg[3],
                       axis_out_reg[2], axis_out_reg[1], axis_out_reg[0],
                       time_out_reg.sample_time_us, time_out_reg.interval_us};

`include "imu_sample_timestamp_scaler_macros.svh"

    `IMU_STS_ASSERT_NOW(a_flag_has_dt, m_tvalid && m_tuser, m_tdata[19:0] != 20'd0, "new sample with zero interval")
    `IMU_STS_ASSERT_NOW(a_reject_no_dt, m_tvalid && !m_tuser, m_tdata[19:0] == 20'd0, "rejected sample with nonzero interval")
    `IMU_STS_ASSERT_NOW(a_dt_in_limit, m_tvalid && m_tuser && !$past(cfg_we), m_tdata[19:0] <= limit_reg, "interval above limit")
    `IMU_STS_ASSERT_NEXT(a_accept_moves, take, s1_valid_reg, "accepted word lost in first stage")
    `IMU_STS_ASSERT_NOW(a_stall_holds_input, out_valid_reg && !m_tready, !s_tready, "input taken during output stall")

endmodule
